[rtl/core/sut_pkg.sv]
// Shared types and constants for the sorted/unsorted word table.
// Used by sut_ram and sorted_or_unsorted_table; no dependencies.
`timescale 1ns / 1ps

package sut_pkg;

  // Table geometry
  localparam int unsigned CAPACITY = 1024;
  localparam int unsigned AddrW    = $clog2(CAPACITY);
  localparam int unsigned CountW   = $clog2(CAPACITY + 1);
  localparam int unsigned IdxW     = 10;
  localparam int unsigned WordW    = 32;

  // Command codes
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_READ   = 2'd3
  } cmd_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_MISS  = 2'd3
  } status_e;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_INS_SHIFT,
    S_INS_PUT,
    S_LIN_SCAN,
    S_BIN_ADDR,
    S_BIN_CMP,
    S_DEL_MOVE,
    S_DEL_SHIFT,
    S_READ_WAIT,
    S_RESP
  } state_e;

  // Memory access bundle from the sequencer to the RAM
  typedef struct packed {
    logic             wr_en;
    logic [AddrW-1:0] wr_addr;
    logic [WordW-1:0] wr_data;
    logic             rd_en;
    logic [AddrW-1:0] rd_addr;
  } ram_req_t;

endpackage

[rtl/core/sut_ram.sv]
// Word store of the table: one write port, one read port, registered read data.
// Depends on sut_pkg for geometry and the request bundle.
`timescale 1ns / 1ps

module sut_ram
  import sut_pkg::*;
(
  input  logic             clk_i,
  input  ram_req_t         req_i,
  output logic [WordW-1:0] rd_data_o
);

  logic [WordW-1:0] mem [CAPACITY];
  logic [WordW-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
  end

  // Read port, data valid the cycle after the request
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_data_q <= mem[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[rtl/core/sorted_or_unsorted_table.sv]
// Table of up to CAPACITY signed 32-bit words kept either in insertion order
// (sorted_mode = 0) or ascending (sorted_mode = 1). The input is not ready
// while a command is in progress and until its result is loaded into the
// output register; a result waiting there does not block the next command.
// Every step goes through the single RAM (one read, one write per cycle) and
// one shared signed comparator. Insert into a full table, and read or delete
// out of range, return a status without touching the RAM. Unsorted insert
// appends and unsorted delete fills the hole with the last entry; sorted
// insert shifts each larger entry up one place and sorted delete moves each
// later entry down one place. Search is linear when unsorted and binary when
// sorted. No clearing pass after reset. Depends on sut_pkg, sut_ram.
`timescale 1ns / 1ps

module sorted_or_unsorted_table
  import sut_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // config: sorted_mode register
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  // command stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // cmd[1:0], value[33:2], index[43:34], zero pad
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // result_word[31:0], status[33:32],
                                      // entry_total[44:34], zero pad
);

  // Registers
  state_e                   state_q, state_d;
  logic                     sorted_mode_q;
  logic [CountW-1:0]        count_q, count_d;
  cmd_e                     cmd_q, cmd_d;
  logic signed [WordW-1:0]  val_q, val_d;
  logic [IdxW-1:0]          idx_q, idx_d;
  logic [AddrW-1:0]         ptr_q, ptr_d;
  logic [CountW-1:0]        lo_q, lo_d;
  logic [CountW-1:0]        hix_q, hix_d;   // upper bound, exclusive
  logic [WordW-1:0]         res_word_q, res_word_d;
  status_e                  res_status_q, res_status_d;
  logic                     out_valid_q, out_valid_d;
  logic [WordW-1:0]         out_word_q, out_word_d;
  status_e                  out_status_q, out_status_d;
  logic [CountW-1:0]        out_total_q, out_total_d;

  ram_req_t                 ram_req;
  logic [WordW-1:0]         rd_data;

  // Shared comparator: last word read against the command's value
  logic                     cmp_eq, cmp_lt, cmp_gt;
  logic [CountW-1:0]        idx_ext;
  logic [CountW-1:0]        ptr_next;
  logic [CountW-1:0]        mid;
  logic                     accept;
  logic                     out_free;

  assign cmp_eq   = ($signed(rd_data) == val_q);
  assign cmp_lt   = ($signed(rd_data) < val_q);
  assign cmp_gt   = !cmp_eq && !cmp_lt;
  assign idx_ext  = CountW'(idx_q);
  assign ptr_next = CountW'(ptr_q) + CountW'(1);
  assign mid      = lo_q + ((hix_q - CountW'(1) - lo_q) >> 1);
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  assign s_axis_tready = (state_q == S_IDLE);

  sut_ram u_ram (
    .clk_i     (clk_i),
    .req_i     (ram_req),
    .rd_data_o (rd_data)
  );

  // Config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sorted_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      sorted_mode_q <= cfg_wdata_i;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload and working registers
  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    val_q        <= val_d;
    idx_q        <= idx_d;
    ptr_q        <= ptr_d;
    lo_q         <= lo_d;
    hix_q        <= hix_d;
    res_word_q   <= res_word_d;
    res_status_q <= res_status_d;
    out_word_q   <= out_word_d;
    out_status_q <= out_status_d;
    out_total_q  <= out_total_d;
  end

  // Sequencer: next state, RAM requests, results
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    cmd_d        = cmd_q;
    val_d        = val_q;
    idx_d        = idx_q;
    ptr_d        = ptr_q;
    lo_d         = lo_q;
    hix_d        = hix_q;
    res_word_d   = res_word_q;
    res_status_d = res_status_q;
    out_word_d   = out_word_q;
    out_status_d = out_status_q;
    out_total_d  = out_total_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    ram_req      = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_d        = cmd_e'(s_axis_tdata[1:0]);
          val_d        = s_axis_tdata[33:2];
          idx_d        = s_axis_tdata[43:34];
          res_word_d   = '0;
          res_status_d = ST_OK;
          state_d      = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        case (cmd_q)
          CMD_INSERT: begin
            if (count_q >= CountW'(CAPACITY)) begin
              res_status_d = ST_FULL;
              state_d      = S_RESP;
            end else if (!sorted_mode_q || count_q == '0) begin
              ram_req.wr_en   = 1'b1;
              ram_req.wr_addr = AddrW'(count_q);
              ram_req.wr_data = val_q;
              count_d         = count_q + CountW'(1);
              state_d         = S_RESP;
            end else begin
              ram_req.rd_en   = 1'b1;
              ram_req.rd_addr = AddrW'(count_q - CountW'(1));
              ptr_d           = AddrW'(count_q - CountW'(1));
              state_d         = S_INS_SHIFT;
            end
          end
          CMD_SEARCH: begin
            if (sorted_mode_q) begin
              lo_d    = '0;
              hix_d   = count_q;
              state_d = S_BIN_ADDR;
            end else if (count_q == '0) begin
              res_word_d   = '1;
              res_status_d = ST_MISS;
              state_d      = S_RESP;
            end else begin
              ram_req.rd_en   = 1'b1;
              ram_req.rd_addr = '0;
              ptr_d           = '0;
              state_d         = S_LIN_SCAN;
            end
          end
          CMD_DELETE: begin
            if (idx_ext >= count_q) begin
              res_status_d = ST_RANGE;
              state_d      = S_RESP;
            end else if (idx_ext + CountW'(1) == count_q) begin
              // last entry: nothing to move in either mode
              count_d = count_q - CountW'(1);
              state_d = S_RESP;
            end else if (!sorted_mode_q) begin
              ram_req.rd_en   = 1'b1;
              ram_req.rd_addr = AddrW'(count_q - CountW'(1));
              state_d         = S_DEL_MOVE;
            end else begin
              ram_req.rd_en   = 1'b1;
              ram_req.rd_addr = AddrW'(idx_ext + CountW'(1));
              ptr_d           = AddrW'(idx_ext + CountW'(1));
              state_d         = S_DEL_SHIFT;
            end
          end
          CMD_READ: begin
            if (idx_ext >= count_q) begin
              res_word_d   = '1;
              res_status_d = ST_RANGE;
              state_d      = S_RESP;
            end else begin
              ram_req.rd_en   = 1'b1;
              ram_req.rd_addr = AddrW'(idx_q);
              state_d         = S_READ_WAIT;
            end
          end
          default: state_d = S_RESP;
        endcase
      end

      // rd_data holds entry ptr; shift it up while larger than the new word
      S_INS_SHIFT: begin
        if (cmp_gt) begin
          ram_req.wr_en   = 1'b1;
          ram_req.wr_addr = AddrW'(ptr_next);
          ram_req.wr_data = rd_data;
          if (ptr_q == '0) begin
            state_d = S_INS_PUT;
          end else begin
            ram_req.rd_en   = 1'b1;
            ram_req.rd_addr = ptr_q - AddrW'(1);
            ptr_d           = ptr_q - AddrW'(1);
          end
        end else begin
          ram_req.wr_en   = 1'b1;
          ram_req.wr_addr = AddrW'(ptr_next);
          ram_req.wr_data = val_q;
          count_d         = count_q + CountW'(1);
          state_d         = S_RESP;
        end
      end

      S_INS_PUT: begin
        ram_req.wr_en   = 1'b1;
        ram_req.wr_addr = '0;
        ram_req.wr_data = val_q;
        count_d         = count_q + CountW'(1);
        state_d         = S_RESP;
      end

      // one entry compared per cycle, first match wins
      S_LIN_SCAN: begin
        if (cmp_eq) begin
          res_word_d = WordW'(ptr_q);
          state_d    = S_RESP;
        end else if (ptr_next == count_q) begin
          res_word_d   = '1;
          res_status_d = ST_MISS;
          state_d      = S_RESP;
        end else begin
          ram_req.rd_en   = 1'b1;
          ram_req.rd_addr = AddrW'(ptr_next);
          ptr_d           = AddrW'(ptr_next);
        end
      end

      // binary search over [lo, hix)
      S_BIN_ADDR: begin
        if (lo_q < hix_q) begin
          ram_req.rd_en   = 1'b1;
          ram_req.rd_addr = AddrW'(mid);
          ptr_d           = AddrW'(mid);
          state_d         = S_BIN_CMP;
        end else begin
          res_word_d   = '1;
          res_status_d = ST_MISS;
          state_d      = S_RESP;
        end
      end

      S_BIN_CMP: begin
        if (cmp_eq) begin
          res_word_d = WordW'(ptr_q);
          state_d    = S_RESP;
        end else begin
          if (cmp_lt) begin
            lo_d = ptr_next;
          end else begin
            hix_d = CountW'(ptr_q);
          end
          state_d = S_BIN_ADDR;
        end
      end

      // last entry fills the hole
      S_DEL_MOVE: begin
        ram_req.wr_en   = 1'b1;
        ram_req.wr_addr = AddrW'(idx_q);
        ram_req.wr_data = rd_data;
        count_d         = count_q - CountW'(1);
        state_d         = S_RESP;
      end

      // rd_data holds entry ptr; move it down one place
      S_DEL_SHIFT: begin
        ram_req.wr_en   = 1'b1;
        ram_req.wr_addr = ptr_q - AddrW'(1);
        ram_req.wr_data = rd_data;
        if (ptr_next < count_q) begin
          ram_req.rd_en   = 1'b1;
          ram_req.rd_addr = AddrW'(ptr_next);
          ptr_d           = AddrW'(ptr_next);
        end else begin
          count_d = count_q - CountW'(1);
          state_d = S_RESP;
        end
      end

      S_READ_WAIT: begin
        res_word_d = rd_data;
        state_d    = S_RESP;
      end

      // hand the result to the output register once it is free
      S_RESP: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_word_d   = res_word_q;
          out_status_d = res_status_q;
          out_total_d  = count_q;
          state_d      = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_total_q, out_status_q, out_word_q};

  // Assertions
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(CAPACITY))
    else $error("entry count above capacity");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (count_q == $past(count_q) || count_q == $past(count_q) + CountW'(1) ||
              count_q == $past(count_q) - CountW'(1)))
    else $error("entry count moved by more than one");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_req.wr_en |-> (CountW'(ram_req.wr_addr) <= count_q))
    else $error("table write beyond the held entries");

  a_count_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |=> (count_q == $past(count_q)))
    else $error("entry count changed while idle");

endmodule
